// ===== hw/rtl/fpace_pkg.sv =====
// ============================================================================
// Frame pacer package
// Types, codes and constants shared by the frame pacer modules.
// ============================================================================
package fpace_pkg;

    // Longest run of skipped frames before a frame must be drawn.
    localparam int MAX_SKIP_RUN = 10;

    // Serial divider sizing: a 33-bit dividend over a 31-bit divisor.
    localparam int DIVN_W    = 33;
    localparam int DIVD_W    = 31;
    localparam int DIV_STEPS = DIVN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Trim limit is one percent of the current period.
    localparam int TRIM_PERCENT = 100;

    // One percent of a 31-bit period by reciprocal multiplication:
    // floor(p / 100) = (p * ceil(2^38 / 100)) >> 38 for every p below 2^31.
    localparam logic [31:0] LIM_RECIP = 32'd2748779070;
    localparam int          LIM_SHIFT = 38;

    // Reset values of registers and state.
    localparam logic [15:0]        SPEED_RESET = 16'd100;
    localparam logic [30:0]        TPS_RESET   = 31'd1000000;
    localparam logic signed [31:0] LEAST_RESET = 32'sh7FFF_FFFF;

    // Action codes of an input word.
    localparam logic [1:0] ACT_FRAME_END = 2'd0;
    localparam logic [1:0] ACT_RESYNC    = 2'd1;
    localparam logic [1:0] ACT_RESTART   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_FRAME_PERIOD  = 3'd0;
    localparam logic [2:0] REG_SPEED_PERCENT = 3'd1;
    localparam logic [2:0] REG_WARP_ENABLE   = 3'd2;
    localparam logic [2:0] REG_FIXED_REFRESH = 3'd3;
    localparam logic [2:0] REG_TICKS_PER_SEC = 3'd4;
    localparam logic [2:0] REG_ALWAYS_SKIP   = 3'd5;

    // Input word.
    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        now_time;
        logic signed [31:0] sound_delay_ticks;
    } in_t;

    // Result word.
    typedef struct packed {
        logic [30:0] wait_ticks;
        logic        skip_next;
        logic        too_slow;
    } out_t;

    // Configuration register contents.
    typedef struct packed {
        logic [30:0] frame_period;
        logic [15:0] speed_percent;
        logic        warp_enable;
        logic [7:0]  fixed_refresh;
        logic [30:0] ticks_per_second;
        logic        always_skip;
    } cfg_t;

    // Divider request and response.
    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] dividend;
        logic [DIVD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVN_W-1:0] quotient;
    } div_rsp_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SCALE,
        ST_DECIDE,
        ST_NUMER,
        ST_DIVQ,
        ST_TRIM,
        ST_EMIT
    } st_t;

endpackage

// ===== hw/rtl/fpace_div.sv =====
// ============================================================================
// Frame pacer serial divider
// Unsigned restoring divider, one quotient bit per cycle, used for the trim
// numerator divided by the frame count of the window.
// ============================================================================
module fpace_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  fpace_pkg::div_req_t req,
    output fpace_pkg::div_rsp_t rsp
);

    logic [fpace_pkg::DIVN_W-1:0]    quo_reg;
    logic [fpace_pkg::DIVN_W-1:0]    quo_next;
    logic [fpace_pkg::DIVD_W-1:0]    rem_reg;
    logic [fpace_pkg::DIVD_W-1:0]    rem_next;
    logic [fpace_pkg::DIVD_W-1:0]    dsr_reg;
    logic [fpace_pkg::DIVD_W-1:0]    dsr_next;
    logic [fpace_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [fpace_pkg::DIV_CNT_W-1:0] cnt_next;
    logic                            busy_reg;
    logic                            busy_next;
    logic                            done_reg;
    logic                            done_next;

    logic [fpace_pkg::DIVD_W:0]      shifted;
    logic [fpace_pkg::DIVD_W+1:0]    trial;

    // Partial remainder with the next dividend bit brought down.
    assign shifted = {rem_reg, quo_reg[fpace_pkg::DIVN_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dsr_reg};

    // One restoring step per cycle while busy.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = fpace_pkg::DIV_CNT_W'(fpace_pkg::DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[fpace_pkg::DIVD_W+1])
            begin
                rem_next = trial[fpace_pkg::DIVD_W-1:0];
                quo_next = {quo_reg[fpace_pkg::DIVN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[fpace_pkg::DIVD_W-1:0];
                quo_next = {quo_reg[fpace_pkg::DIVN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == fpace_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hw/rtl/fpace_cfg.sv =====
// ============================================================================
// Frame pacer configuration registers
// Holds the six settings and flags writes that must restart pacing.
// ============================================================================
module fpace_cfg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [30:0]     cfg_data,
    output fpace_pkg::cfg_t cfg,
    output logic            arm
);

    fpace_pkg::cfg_t cfg_reg;
    fpace_pkg::cfg_t cfg_next;
    logic            wr;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    // A new period, speed or warp setting restarts pacing and the trim.
    always_comb
    begin
        arm = 1'b0;
        if (wr)
        begin
            arm = cfg_index inside {fpace_pkg::REG_FRAME_PERIOD,
                                    fpace_pkg::REG_SPEED_PERCENT,
                                    fpace_pkg::REG_WARP_ENABLE};
        end
    end

    // Register file update; unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (cfg_index)
                fpace_pkg::REG_FRAME_PERIOD:  cfg_next.frame_period     = cfg_data;
                fpace_pkg::REG_SPEED_PERCENT: cfg_next.speed_percent    = cfg_data[15:0];
                fpace_pkg::REG_WARP_ENABLE:   cfg_next.warp_enable      = cfg_data[0];
                fpace_pkg::REG_FIXED_REFRESH: cfg_next.fixed_refresh    = cfg_data[7:0];
                fpace_pkg::REG_TICKS_PER_SEC: cfg_next.ticks_per_second = cfg_data;
                fpace_pkg::REG_ALWAYS_SKIP:   cfg_next.always_skip      = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_period     <= '0;
            cfg_reg.speed_percent    <= fpace_pkg::SPEED_RESET;
            cfg_reg.warp_enable      <= 1'b0;
            cfg_reg.fixed_refresh    <= '0;
            cfg_reg.ticks_per_second <= fpace_pkg::TPS_RESET;
            cfg_reg.always_skip      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/frame_pacer_with_skip_and_av_trim_unit.sv =====
// ============================================================================
// Frame pacer with frame skip and sound-sync trim
// Computes the wait before the next frame, the skip decision and the too-slow
// flag once per frame end, and trims the frame period once per second.
// ============================================================================
// A frame-end word passes through the diff, scale and decide states to emit;
// when the trim window closes with a sound delay seen, it also passes through
// numer, divq (one pass through the 33-step serial divider) and trim. One word
// at a time, the next taken once back in idle, later while a result is stalled.
// Resync and restart words give no result. Reset: async, active low; clears
// pacing state, arms a restart and a resync, no clearing pass.
module frame_pacer_with_skip_and_av_trim_unit
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  fpace_pkg::in_t   item,
    output logic             res_valid,
    input  logic             res_stall,
    output fpace_pkg::out_t  res,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [30:0]      cfg_data
);

    fpace_pkg::cfg_t     cfg;
    logic                cfg_arm;
    fpace_pkg::div_req_t div_req;
    fpace_pkg::div_rsp_t div_rsp;

    // Sequencer and pacing state.
    fpace_pkg::st_t     state_reg, state_next;
    logic [31:0]        now_reg, now_next;
    logic signed [31:0] sound_reg, sound_next;
    logic [31:0]        next_start_reg, next_start_next;
    logic [3:0]         skip_run_reg, skip_run_next;
    logic [31:0]        tws_reg, tws_next;
    logic [30:0]        fiw_reg, fiw_next;
    logic signed [31:0] least_reg, least_next;
    logic               least_valid_reg, least_valid_next;
    logic signed [31:0] prev_reg, prev_next;
    logic [30:0]        cp_reg, cp_next;
    logic               resync_reg, resync_next;
    logic               restart_reg, restart_next;

    // Working registers of one frame.
    logic signed [31:0] delay_reg, delay_next;
    logic [46:0]        prod_reg, prod_next;
    logic               win_close_reg, win_close_next;
    logic [48:0]        prod3_reg, prod3_next;
    logic signed [38:0] d100_reg, d100_next;
    logic [30:0]        res_wait_reg, res_wait_next;
    logic               res_skip_reg, res_skip_next;
    logic               res_slow_reg, res_slow_next;
    logic               neg_reg, neg_next;
    logic [32:0]        quot_reg, quot_next;
    logic [24:0]        lim_reg, lim_next;

    // Result register.
    logic               res_valid_reg, res_valid_next;
    fpace_pkg::out_t    res_reg, res_next;

    // Combinational helpers.
    logic               accept;
    logic [31:0]        delay_raw;
    logic [31:0]        win_raw;
    logic               win_ge;
    logic [46:0]        prod_full;
    logic [48:0]        prod3_full;
    logic signed [38:0] dx;
    logic signed [38:0] d100_full;
    logic               late_gt;
    logic               slow;
    logic [32:0]        ahead;
    logic [30:0]        wait_val;
    logic [32:0]        sd_full;
    logic signed [31:0] sd_sat;
    logic               run_lt;
    logic [4:0]         run_plus;
    logic               speed_zero;
    logic               skip_cond;
    logic signed [32:0] least_x;
    logic signed [32:0] half_sum;
    logic signed [32:0] half;
    logic [33:0]        num;
    logic [33:0]        num_mag;
    logic [62:0]        lim_prod;
    logic [24:0]        adj_mag;
    logic [31:0]        cp_sum;
    logic [30:0]        cp_trim;

    fpace_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .arm       (cfg_arm)
    );

    fpace_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign item_stall = (state_reg != fpace_pkg::ST_IDLE);
    assign accept     = item_valid && !item_stall;

    // Lag behind the due time and age of the trim window.
    assign delay_raw = now_reg - next_start_reg;
    assign win_raw   = now_reg - tws_reg;
    assign win_ge    = $signed(win_raw) >= $signed({1'b0, cfg.ticks_per_second});
    assign prod_full = {16'd0, cp_reg} * {31'd0, cfg.speed_percent};

    // Skip threshold: delay > 3*period*speed/100 is 100*delay > 3*period*speed.
    assign prod3_full = {2'b00, prod_reg} + {1'b0, prod_reg, 1'b0};
    assign dx         = {{7{delay_reg[31]}}, delay_reg};
    assign d100_full  = (dx <<< 6) + (dx <<< 5) + (dx <<< 2);
    assign late_gt    = $signed({{11{d100_reg[38]}}, d100_reg}) > $signed({1'b0, prod3_reg});

    // Too slow once the lag reaches one second.
    assign slow = $signed(delay_reg) >= $signed({1'b0, cfg.ticks_per_second});

    // Wait time is the negated lag, saturated to 31 bits.
    assign ahead    = 33'd0 - {delay_reg[31], delay_reg};
    assign wait_val = ahead[31] ? '1 : ahead[30:0];

    // Sound delay less the lag, saturated to 32 bits.
    assign sd_full = {sound_reg[31], sound_reg} - {delay_reg[31], delay_reg};
    assign sd_sat  = (sd_full[32] != sd_full[31]) ?
                     (sd_full[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) :
                     $signed(sd_full[31:0]);

    // Skip decision.
    assign run_lt     = skip_run_reg < 4'(fpace_pkg::MAX_SKIP_RUN);
    assign run_plus   = {1'b0, skip_run_reg} + 5'd1;
    assign speed_zero = (cfg.speed_percent == 16'd0);
    assign skip_cond  = cfg.always_skip ||
                        (run_lt &&
                         (cfg.warp_enable ||
                          ({3'b000, run_plus} < cfg.fixed_refresh) ||
                          ((speed_zero || late_gt) && (cfg.fixed_refresh == 8'd0))));

    // Trim numerator: least - previous + least/2, halved toward zero.
    assign least_x  = {least_reg[31], least_reg};
    assign half_sum = least_x + $signed({32'd0, least_reg[31]});
    assign half     = half_sum >>> 1;
    assign num      = {least_x[32], least_x} - {{2{prev_reg[31]}}, prev_reg} +
                      {half[32], half};
    assign num_mag  = num[33] ? (34'd0 - num) : num;

    // One percent of the current period by reciprocal multiplication.
    assign lim_prod = {32'd0, cp_reg} * {31'd0, fpace_pkg::LIM_RECIP};

    // Trim step clamped to one percent, period held in 31 bits.
    assign adj_mag = (quot_reg > {8'd0, lim_reg}) ? lim_reg : quot_reg[24:0];
    assign cp_sum  = neg_reg ? ({1'b0, cp_reg} + {7'd0, adj_mag}) :
                               ({1'b0, cp_reg} - {7'd0, adj_mag});
    assign cp_trim = cp_sum[31] ? '1 : cp_sum[30:0];

    // Sequencer: next state and all register updates.
    always_comb
    begin
        state_next       = state_reg;
        now_next         = now_reg;
        sound_next       = sound_reg;
        next_start_next  = next_start_reg;
        skip_run_next    = skip_run_reg;
        tws_next         = tws_reg;
        fiw_next         = fiw_reg;
        least_next       = least_reg;
        least_valid_next = least_valid_reg;
        prev_next        = prev_reg;
        cp_next          = cp_reg;
        resync_next      = resync_reg;
        restart_next     = restart_reg;
        delay_next       = delay_reg;
        prod_next        = prod_reg;
        win_close_next   = win_close_reg;
        prod3_next       = prod3_reg;
        d100_next        = d100_reg;
        res_wait_next    = res_wait_reg;
        res_skip_next    = res_skip_reg;
        res_slow_next    = res_slow_reg;
        neg_next         = neg_reg;
        quot_next        = quot_reg;
        lim_next         = lim_reg;
        res_next         = res_reg;
        res_valid_next   = res_valid_reg && res_stall;
        div_req          = '0;

        if (cfg_arm)
        begin
            restart_next = 1'b1;
            resync_next  = 1'b1;
        end

        case (state_reg)
            fpace_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.action)
                        fpace_pkg::ACT_FRAME_END:
                        begin
                            now_next   = item.now_time;
                            sound_next = item.sound_delay_ticks;
                            if (restart_reg)
                            begin
                                restart_next    = 1'b0;
                                next_start_next = item.now_time;
                                skip_run_next   = '0;
                            end
                            if (resync_reg)
                            begin
                                resync_next      = 1'b0;
                                tws_next         = item.now_time;
                                fiw_next         = '0;
                                least_next       = fpace_pkg::LEAST_RESET;
                                least_valid_next = 1'b0;
                                prev_next        = '0;
                                cp_next          = cfg.frame_period;
                            end
                            state_next = fpace_pkg::ST_DIFF;
                        end
                        fpace_pkg::ACT_RESYNC:
                        begin
                            resync_next = 1'b1;
                        end
                        fpace_pkg::ACT_RESTART:
                        begin
                            restart_next = 1'b1;
                            resync_next  = 1'b1;
                        end
                        default:
                        begin
                            state_next = fpace_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            fpace_pkg::ST_DIFF:
            begin
                delay_next     = $signed(delay_raw);
                prod_next      = prod_full;
                win_close_next = win_ge;
                state_next     = fpace_pkg::ST_SCALE;
            end

            fpace_pkg::ST_SCALE:
            begin
                prod3_next = prod3_full;
                d100_next  = d100_full;
                state_next = fpace_pkg::ST_DECIDE;
            end

            fpace_pkg::ST_DECIDE:
            begin
                res_wait_next = (!cfg.warp_enable && !speed_zero && delay_reg[31]) ?
                                wait_val : '0;
                res_skip_next = skip_cond;
                res_slow_next = slow;
                if (skip_cond)
                begin
                    if (skip_run_reg != 4'hF)
                    begin
                        skip_run_next = skip_run_reg + 4'd1;
                    end
                end
                else
                begin
                    skip_run_next = '0;
                end
                if (slow)
                begin
                    resync_next = 1'b1;
                end
                if (fiw_reg != '1)
                begin
                    fiw_next = fiw_reg + 31'd1;
                end
                state_next = fpace_pkg::ST_EMIT;
                if (win_close_reg)
                begin
                    tws_next = now_reg;
                    if (least_valid_reg)
                    begin
                        state_next = fpace_pkg::ST_NUMER;
                    end
                end
                else if (sound_reg != 32'sd0)
                begin
                    if (!least_valid_reg || (sd_sat < least_reg))
                    begin
                        least_next       = sd_sat;
                        least_valid_next = 1'b1;
                    end
                end
            end

            fpace_pkg::ST_NUMER:
            begin
                // Divide the numerator magnitude by the frame count, and take
                // one percent of the current period meanwhile.
                neg_next         = num[33];
                lim_next         = lim_prod[fpace_pkg::LIM_SHIFT +: 25];
                div_req.start    = 1'b1;
                div_req.dividend = num_mag[32:0];
                div_req.divisor  = fiw_reg;
                state_next       = fpace_pkg::ST_DIVQ;
            end

            fpace_pkg::ST_DIVQ:
            begin
                if (div_rsp.done)
                begin
                    quot_next  = div_rsp.quotient;
                    state_next = fpace_pkg::ST_TRIM;
                end
            end

            fpace_pkg::ST_TRIM:
            begin
                cp_next          = cp_trim;
                fiw_next         = '0;
                prev_next        = least_reg;
                least_next       = fpace_pkg::LEAST_RESET;
                least_valid_next = 1'b0;
                state_next       = fpace_pkg::ST_EMIT;
            end

            fpace_pkg::ST_EMIT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.wait_ticks = res_wait_reg;
                    res_next.skip_next  = res_skip_reg;
                    res_next.too_slow   = res_slow_reg;
                    res_valid_next      = 1'b1;
                    next_start_next     = next_start_reg + {1'b0, cp_reg};
                    state_next          = fpace_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fpace_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpace_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pacing and trim state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_start_reg  <= '0;
            skip_run_reg    <= '0;
            tws_reg         <= '0;
            fiw_reg         <= '0;
            least_reg       <= fpace_pkg::LEAST_RESET;
            least_valid_reg <= 1'b0;
            prev_reg        <= '0;
            cp_reg          <= '0;
            resync_reg      <= 1'b1;
            restart_reg     <= 1'b1;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            next_start_reg  <= next_start_next;
            skip_run_reg    <= skip_run_next;
            tws_reg         <= tws_next;
            fiw_reg         <= fiw_next;
            least_reg       <= least_next;
            least_valid_reg <= least_valid_next;
            prev_reg        <= prev_next;
            cp_reg          <= cp_next;
            resync_reg      <= resync_next;
            restart_reg     <= restart_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Working registers and result payload.
    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        sound_reg     <= sound_next;
        delay_reg     <= delay_next;
        prod_reg      <= prod_next;
        win_close_reg <= win_close_next;
        prod3_reg     <= prod3_next;
        d100_reg      <= d100_next;
        res_wait_reg  <= res_wait_next;
        res_skip_reg  <= res_skip_next;
        res_slow_reg  <= res_slow_next;
        neg_reg       <= neg_next;
        quot_reg      <= quot_next;
        lim_reg       <= lim_next;
        res_reg       <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/fpace_chk.sv =====
// ============================================================================
// Frame pacer port checker
// Watches the top-level ports of the frame pacer for ordering slips.
// ============================================================================
module fpace_chk
(
    input logic            clk,
    input logic            rst_n,
    input logic            item_valid,
    input logic            item_stall,
    input fpace_pkg::in_t  item,
    input logic            res_valid,
    input logic            res_stall,
    input fpace_pkg::out_t res
);

    // A stalled result word stays put.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // A frame-end word keeps the input stalled while it is worked on.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.action == fpace_pkg::ACT_FRAME_END)
        |=> item_stall)
        else $error("input not stalled after a frame-end word");

    // A new result comes only at the end of a busy spell.
    a_res_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(item_stall) && !item_stall)
        else $error("result word appeared outside the end of a frame");

    // A frame that is a second late is never told to wait.
    a_slow_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.too_slow |-> (res.wait_ticks == 31'd0))
        else $error("too-slow frame carries a wait");

endmodule

bind frame_pacer_with_skip_and_av_trim_unit fpace_chk u_fpace_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
);

// ===== bench/tb_top.sv =====
// ============================================================================
// Frame pacer testbench
// Drives frame-end, resync and restart words into the frame pacer under
// several register settings and checks every result word against a
// cycle-free model of the pacing, skip and sound-trim rules kept here.
// ============================================================================
module tb_top;

    // Codes the package leaves unnamed.
    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // Arithmetic limits and scale factors of the pacing rules.
    localparam longint PERIOD_CAP    = 64'sh7FFF_FFFF;
    localparam longint S32_MAX       = 64'sh7FFF_FFFF;
    localparam longint S32_MIN       = -64'sh8000_0000;
    localparam longint PERCENT_SCALE = 100;
    localparam longint LATE_FRAMES   = 3;
    localparam int     SKIP_RUN_CAP  = 15;

    // Run control.
    localparam int SETTLE_CYCLES = 100;
    localparam int STUCK_LIMIT   = 2000;
    localparam int REPORT_CAP    = 40;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   item_valid = 1'b0;
    logic   item_stall;
    fpace_pkg::in_t  item = '0;
    logic   res_valid;
    logic   res_stall = 1'b0;
    fpace_pkg::out_t res;
    logic   cfg_valid = 1'b0;
    logic   cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;

    // Words waiting to be sent and results waiting to arrive.
    fpace_pkg::in_t  host_events[$];
    fpace_pkg::out_t paced_results[$];
    fpace_pkg::out_t due_word;
    fpace_pkg::out_t predicted;

    int     send_gap = 0;
    int     stall_left = 0;
    bit     calm_phase = 1'b0;
    int     mismatch_count = 0;
    int     stuck_cycles = 0;
    bit     moved;
    logic [31:0] host_clock = '0;

    // Model copy of the registers and the pacing state.
    fpace_pkg::cfg_t shadow;
    logic [31:0] ps_next_start = '0;
    int          ps_skip_run = 0;
    logic [31:0] ps_window_start = '0;
    longint      ps_frames = 0;
    longint      ps_least = S32_MAX;
    bit          ps_least_valid = 1'b0;
    longint      ps_prev_least = 0;
    longint      ps_period = 0;
    bit          ps_resync = 1'b1;
    bit          ps_restart = 1'b1;

    frame_pacer_with_skip_and_av_trim_unit dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Signed difference of two wrapping timestamps.
    function automatic longint time_gap(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return longint'($signed(d));
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Applies one word to the pacing state; returns one when it yields a result.
    function automatic bit pace_frame(input fpace_pkg::in_t w, output fpace_pkg::out_t r);
        longint lag, spd, fr, tps, wt, sound, sd, adj, lim;
        bit     skip, slow;
        r = '0;
        wt = 0;
        if (w.action == fpace_pkg::ACT_RESYNC)
        begin
            ps_resync = 1'b1;
            return 1'b0;
        end
        if (w.action == fpace_pkg::ACT_RESTART)
        begin
            ps_restart = 1'b1;
            ps_resync = 1'b1;
            return 1'b0;
        end
        if (w.action != fpace_pkg::ACT_FRAME_END)
            return 1'b0;

        sound = longint'($signed(w.sound_delay_ticks));
        spd = shadow.speed_percent;
        fr = shadow.fixed_refresh;
        tps = shadow.ticks_per_second;

        if (ps_restart)
        begin
            ps_restart = 1'b0;
            ps_next_start = w.now_time;
            ps_skip_run = 0;
        end
        if (ps_resync)
        begin
            ps_resync = 1'b0;
            ps_window_start = w.now_time;
            ps_frames = 0;
            ps_least = S32_MAX;
            ps_least_valid = 1'b0;
            ps_prev_least = 0;
            ps_period = shadow.frame_period;
        end

        lag = time_gap(w.now_time, ps_next_start);
        if (!shadow.warp_enable && spd != 0 && lag < 0)
            wt = (-lag > PERIOD_CAP) ? PERIOD_CAP : -lag;

        // Skip decision: forced, fixed refresh, warp, or running late.
        if (shadow.always_skip ||
            (ps_skip_run < fpace_pkg::MAX_SKIP_RUN &&
             (shadow.warp_enable || longint'(ps_skip_run) + 1 < fr ||
              ((spd == 0 || lag > LATE_FRAMES * ps_period * spd / PERCENT_SCALE) &&
               fr == 0))))
        begin
            skip = 1'b1;
            if (ps_skip_run < SKIP_RUN_CAP)
                ps_skip_run++;
        end
        else
        begin
            skip = 1'b0;
            ps_skip_run = 0;
        end

        slow = (lag >= tps);
        if (slow)
            ps_resync = 1'b1;
        if (ps_frames < PERIOD_CAP)
            ps_frames++;

        // Once per second the period moves toward the least sound delay.
        if (time_gap(w.now_time, ps_window_start) >= tps)
        begin
            if (ps_least_valid)
            begin
                adj = (ps_least - ps_prev_least + ps_least / 2) / ps_frames;
                lim = ps_period / fpace_pkg::TRIM_PERCENT;
                if (adj > lim)
                    adj = lim;
                else if (adj < -lim)
                    adj = -lim;
                ps_period = ps_period - adj;
                if (ps_period < 0)
                    ps_period = 0;
                if (ps_period > PERIOD_CAP)
                    ps_period = PERIOD_CAP;
                ps_frames = 0;
                ps_prev_least = ps_least;
                ps_least = S32_MAX;
                ps_least_valid = 1'b0;
            end
            ps_window_start = w.now_time;
        end
        else if (sound != 0)
        begin
            sd = sound - lag;
            if (sd > S32_MAX)
                sd = S32_MAX;
            if (sd < S32_MIN)
                sd = S32_MIN;
            if (!ps_least_valid || sd < ps_least)
            begin
                ps_least = sd;
                ps_least_valid = 1'b1;
            end
        end

        ps_next_start = ps_next_start + ps_period[31:0];
        r.wait_ticks = wt[30:0];
        r.skip_next = skip;
        r.too_slow = slow;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Sender: takes words from the pending queue with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            send_gap <= 0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (send_gap > 0)
            begin
                item_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (host_events.size() != 0)
            begin
                item <= host_events.pop_front();
                item_valid <= 1'b1;
                send_gap <= pick_gap();
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure: stall runs of random length.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_stall <= 1'b0;
            stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    // Monitor: predicts on accepted words, checks result words, tracks registers.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (res_valid && !res_stall)
            begin
                moved = 1'b1;
                if (paced_results.size() == 0)
                begin
                    report_mismatch("result word arrived with nothing expected");
                end
                else
                begin
                    due_word = paced_results.pop_front();
                    if (res.wait_ticks !== due_word.wait_ticks)
                        report_mismatch($sformatf("wait_ticks %0d, expected %0d",
                                                  res.wait_ticks, due_word.wait_ticks));
                    if (res.skip_next !== due_word.skip_next)
                        report_mismatch($sformatf("skip_next %b, expected %b",
                                                  res.skip_next, due_word.skip_next));
                    if (res.too_slow !== due_word.too_slow)
                        report_mismatch($sformatf("too_slow %b, expected %b",
                                                  res.too_slow, due_word.too_slow));
                end
            end
            if (item_valid && !item_stall)
            begin
                moved = 1'b1;
                if (pace_frame(item, predicted))
                    paced_results.push_back(predicted);
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                case (cfg_index)
                    fpace_pkg::REG_FRAME_PERIOD:  shadow.frame_period = cfg_data;
                    fpace_pkg::REG_SPEED_PERCENT: shadow.speed_percent = cfg_data[15:0];
                    fpace_pkg::REG_WARP_ENABLE:   shadow.warp_enable = cfg_data[0];
                    fpace_pkg::REG_FIXED_REFRESH: shadow.fixed_refresh = cfg_data[7:0];
                    fpace_pkg::REG_TICKS_PER_SEC: shadow.ticks_per_second = cfg_data;
                    fpace_pkg::REG_ALWAYS_SKIP:   shadow.always_skip = cfg_data[0];
                    default: ;
                endcase
                // Pacing registers restart the pacing and the trim.
                if (cfg_index == fpace_pkg::REG_FRAME_PERIOD ||
                    cfg_index == fpace_pkg::REG_SPEED_PERCENT ||
                    cfg_index == fpace_pkg::REG_WARP_ENABLE)
                begin
                    ps_restart = 1'b1;
                    ps_resync = 1'b1;
                end
            end

            // Watchdog on a run that no longer makes progress.
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Writes all six registers; unused upper data bits carry noise.
    task automatic program_pacer(input logic [30:0] fp, input logic [15:0] spd,
                                 input logic warp, input logic [7:0] fr,
                                 input logic [30:0] tps, input logic skip_all);
        write_reg(fpace_pkg::REG_FRAME_PERIOD, fp);
        write_reg(fpace_pkg::REG_SPEED_PERCENT, {15'($urandom), spd});
        write_reg(fpace_pkg::REG_WARP_ENABLE, {30'($urandom), warp});
        write_reg(fpace_pkg::REG_FIXED_REFRESH, {23'($urandom), fr});
        write_reg(fpace_pkg::REG_TICKS_PER_SEC, tps);
        write_reg(fpace_pkg::REG_ALWAYS_SKIP, {30'($urandom), skip_all});
    endtask

    // Waits until the block has nothing left in flight.
    task automatic drain();
        while (host_events.size() != 0 || item_valid || paced_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_word(input logic [1:0] act, input logic [31:0] now,
                             input logic [31:0] snd);
        fpace_pkg::in_t w;
        w.action = act;
        w.now_time = now;
        w.sound_delay_ticks = snd;
        host_events.push_back(w);
    endtask

    // Frame sequence: host time advances about one frame per word, with
    // occasional stalls of the host, time jumps and stray actions.
    task automatic queue_frames(input int count, input longint step, input longint tps_v);
        longint pace, adv, cap;
        int     r;
        fpace_pkg::in_t w;
        pace = $urandom_range(85, 115);
        cap = (step * 4 > S32_MAX) ? S32_MAX : step * 4;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                w.action = fpace_pkg::ACT_RESYNC;
            else if (r < 6)
                w.action = fpace_pkg::ACT_RESTART;
            else if (r < 8)
                w.action = ACT_UNUSED;
            else
                w.action = fpace_pkg::ACT_FRAME_END;

            r = $urandom_range(0, 99);
            if (r < 4)
                adv = tps_v + $urandom_range(0, 1000);
            else
                adv = step * pace / PERCENT_SCALE +
                      longint'($urandom_range(0, 400)) * step / 1000 - step / 5;
            if (r >= 4 && r < 6)
                host_clock = $urandom;
            else
                host_clock = host_clock + 32'(adv);
            w.now_time = host_clock;

            r = $urandom_range(0, 99);
            if (r < 25)
                w.sound_delay_ticks = '0;
            else if (r < 65)
                w.sound_delay_ticks = $urandom_range(0, 32'(cap));
            else if (r < 80)
                w.sound_delay_ticks = 32'($urandom_range(0, 65535)) - 32'd32768;
            else if (r < 92)
                w.sound_delay_ticks = $urandom;
            else
                case ($urandom_range(0, 3))
                    0: w.sound_delay_ticks = 32'h8000_0000;
                    1: w.sound_delay_ticks = 32'h7FFF_FFFF;
                    2: w.sound_delay_ticks = 32'hFFFF_FFFF;
                    default: w.sound_delay_ticks = 32'd1;
                endcase
            host_events.push_back(w);
        end
    endtask

    initial
    begin : stimulus
        longint fp_v, step, tps_v;
        int     r;
        logic [15:0] spd_v;
        logic [7:0]  fr_v;

        shadow = '0;
        shadow.speed_percent = fpace_pkg::SPEED_RESET;
        shadow.ticks_per_second = fpace_pkg::TPS_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: timestamp and sound delay extremes, every action.
        push_word(ACT_UNUSED, 32'd123, 32'd5);
        push_word(fpace_pkg::ACT_FRAME_END, 32'd0, 32'd0);
        push_word(fpace_pkg::ACT_FRAME_END, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        push_word(fpace_pkg::ACT_FRAME_END, 32'h7FFF_FFFF, 32'h8000_0000);
        push_word(fpace_pkg::ACT_RESYNC, 32'd0, 32'd0);
        push_word(fpace_pkg::ACT_FRAME_END, 32'h8000_0000, 32'hFFFF_FFFF);
        push_word(fpace_pkg::ACT_RESTART, 32'd0, 32'd0);
        push_word(fpace_pkg::ACT_FRAME_END, 32'd1000, 32'd1);
        drain();

        // Nominal pacing: on time, early, late, far too late, wrap.
        program_pacer(31'd20000, 16'd100, 1'b0, 8'd0, 31'd1000000, 1'b0);
        write_reg(REG_SPARE_LO, 31'($urandom));
        write_reg(REG_SPARE_HI, 31'($urandom));
        push_word(fpace_pkg::ACT_FRAME_END, 32'd1000, 32'd0);
        push_word(fpace_pkg::ACT_FRAME_END, 32'd21000, 32'd500);
        push_word(fpace_pkg::ACT_FRAME_END, 32'd36000, 32'd400);
        push_word(fpace_pkg::ACT_FRAME_END, 32'd131000, 32'd300);
        push_word(fpace_pkg::ACT_FRAME_END, 32'd1631000, 32'd200);
        push_word(fpace_pkg::ACT_FRAME_END, 32'hFFFF_FF00, 32'd100);
        push_word(fpace_pkg::ACT_FRAME_END, 32'h0000_0100, 32'hFFFF_FF9C);
        drain();

        // Zero ticks per second with the longest period and top speed.
        program_pacer(31'h7FFF_FFFF, 16'hFFFF, 1'b0, 8'hFF, 31'd0, 1'b0);
        push_word(fpace_pkg::ACT_FRAME_END, 32'd0, 32'h7FFF_FFFF);
        push_word(fpace_pkg::ACT_FRAME_END, 32'h7FFF_FFFF, 32'h8000_0000);
        push_word(fpace_pkg::ACT_FRAME_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(fpace_pkg::ACT_FRAME_END, 32'd12345, 32'd1);
        drain();

        // Random phases, the first two at the register extremes.
        for (int ph = 0; ph < 10; ph++)
        begin
            calm_phase = (ph % 4 == 3);
            if (ph == 0)
            begin
                program_pacer(31'h7FFF_FFFF, 16'hFFFF, 1'b1, 8'hFF, 31'h7FFF_FFFF, 1'b1);
                queue_frames(40, PERIOD_CAP, PERIOD_CAP);
            end
            else if (ph == 1)
            begin
                program_pacer(31'd0, 16'd0, 1'b0, 8'd0, 31'd1, 1'b0);
                queue_frames(40, $urandom_range(200, 5000), 1);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    fp_v = $urandom_range(500, 50000);
                else if (r < 80)
                    fp_v = $urandom_range(1, 99);
                else if (r < 90)
                    fp_v = $urandom_range(0, 32'h7FFF_FFFF);
                else
                    fp_v = 0;
                step = (fp_v != 0) ? fp_v : $urandom_range(200, 20000);

                r = $urandom_range(0, 99);
                if (r < 50)
                    spd_v = 16'd100;
                else if (r < 70)
                    spd_v = 16'($urandom_range(25, 400));
                else if (r < 80)
                    spd_v = 16'd0;
                else if (r < 90)
                    spd_v = 16'hFFFF;
                else
                    spd_v = 16'($urandom);

                r = $urandom_range(0, 99);
                if (r < 60)
                    fr_v = 8'd0;
                else if (r < 85)
                    fr_v = 8'($urandom_range(1, 5));
                else
                    fr_v = 8'($urandom);

                r = $urandom_range(0, 99);
                if (r < 75)
                    tps_v = step * $urandom_range(8, 60);
                else if (r < 85)
                    tps_v = $urandom_range(0, 32'h7FFF_FFFF);
                else if (r < 95)
                    tps_v = $urandom_range(1, 32'(step));
                else
                    tps_v = 0;
                if (tps_v > PERIOD_CAP)
                    tps_v = PERIOD_CAP;

                program_pacer(31'(fp_v), spd_v, ($urandom_range(0, 9) == 0), fr_v,
                              31'(tps_v), ($urandom_range(0, 9) == 0));
                if ($urandom_range(0, 4) == 0)
                    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                              31'($urandom));
                queue_frames(130, step, tps_v);
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
